### src/tga_rle_pkg.sv
`default_nettype none

package tga_rle_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES = 1'b1;

  localparam logic [2:0] PIXEL_BYTES_RST = 3'd3;
  localparam logic [7:0] RUN_FLAG = 8'h80;
  localparam logic [7:0] RUN_BIAS = 8'd127;

  // Bytes still to emit for one pixel: up to 128 pixels of 4 bytes
  localparam int unsigned EMIT_CNT_W = 10;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RUN    = 2'd1,
    PH_RAW    = 2'd2
  } pkt_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SIZE = 2'd1,
    ST_EMIT = 2'd2
  } ctrl_state_e;

  // Sequencer to word packer
  typedef struct packed {
    logic [31:0]           pixel;
    logic [2:0]            pb;
    logic [1:0]            lane;
    logic [EMIT_CNT_W-1:0] left;
  } emit_req_t;

  // Word packer back to sequencer
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  count;
    logic [1:0]  next_lane;
    logic        final_word;
  } pack_rsp_t;

  // Byte lane of a pixel for stream position pos (pos mod pb), pb in 1..4
  function automatic logic [1:0] lane_of(logic [3:0] pos, logic [2:0] pb);
    logic [1:0] r;
    case (pb)
      3'd1: r = 2'd0;
      3'd2: r = {1'b0, pos[0]};
      3'd3: begin
        case (pos)
          4'd1, 4'd4, 4'd7, 4'd10: r = 2'd1;
          4'd2, 4'd5, 4'd8, 4'd11: r = 2'd2;
          default:                 r = 2'd0;
        endcase
      end
      default: r = pos[1:0];
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### src/tga_rle_pack.sv
`default_nettype none

// Word packer: builds one output word of up to eight bytes per use by
// replicating the held pixel from the current byte lane on.
module tga_rle_pack (
  input  tga_rle_pkg::emit_req_t req_i,
  output tga_rle_pkg::pack_rsp_t rsp_o
);

  logic [3:0] count;
  logic [1:0] sel [8];

  assign count = (req_i.left > tga_rle_pkg::EMIT_CNT_W'(8)) ? 4'd8 : req_i.left[3:0];

  always_comb begin
    rsp_o.word       = '0;
    rsp_o.count      = count;
    rsp_o.final_word = (req_i.left <= tga_rle_pkg::EMIT_CNT_W'(8));
    rsp_o.next_lane  = tga_rle_pkg::lane_of(4'(req_i.lane) + 4'd8, req_i.pb);
    for (int j = 0; j < 8; j++) begin
      sel[j] = tga_rle_pkg::lane_of(4'(req_i.lane) + 4'(j), req_i.pb);
      if (4'(j) < count) begin
        rsp_o.word[8*j +: 8] = req_i.pixel[{sel[j], 3'b000} +: 8];
      end
    end
  end

endmodule

`default_nettype wire

### src/tga_rle_ctrl.sv
`default_nettype none

// Packet parser and emit sequencer with the output register.
module tga_rle_ctrl #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [2:0]             pb_i,
  input  wire logic [COUNT_BITS-1:0]  total_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,
  input  wire logic                   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [63:0]                 out_word_o,
  output logic [3:0]                  out_count_o,
  output logic                        m_axis_tlast,
  output logic                        m_axis_tuser,
  output tga_rle_pkg::emit_req_t      req_o,
  input  tga_rle_pkg::pack_rsp_t      rsp_i
);

  localparam int unsigned CW = tga_rle_pkg::EMIT_CNT_W;
  localparam int unsigned WW = (COUNT_BITS > CW) ? COUNT_BITS : CW;

  tga_rle_pkg::ctrl_state_e state_q, state_d;
  tga_rle_pkg::pkt_phase_e  phase_q, phase_d, e_phase;
  logic [7:0]            left_q, left_d, e_left;
  logic [1:0]            gidx_q, gidx_d, e_gidx;
  logic [COUNT_BITS-1:0] bw_q, bw_d, e_bw;
  logic                  fin_q, fin_d, e_fin;
  logic [31:0]           gather_q, gather_d;
  logic [7:0]            reps_q, reps_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [1:0]            lane_q, lane_d;
  logic                  done_q, done_d;

  logic                  mv_q, mv_d;
  logic [63:0]           mword_q;
  logic [3:0]            mcount_q;
  logic                  mlast_q, mdone_q;

  logic                  s_hs, skip, pix_done, out_free, load;
  logic [CW-1:0]         n_full, n_eff;
  logic [COUNT_BITS-1:0] remaining, bw_sum;

  assign s_hs     = s_axis_tvalid && s_axis_tready;
  assign out_free = !mv_q || m_axis_tready;

  // begins_image clears state ahead of this byte
  assign e_phase = s_axis_tuser ? tga_rle_pkg::PH_HEADER : phase_q;
  assign e_left  = s_axis_tuser ? 8'd0 : left_q;
  assign e_gidx  = s_axis_tuser ? 2'd0 : gidx_q;
  assign e_bw    = s_axis_tuser ? '0 : bw_q;
  assign e_fin   = s_axis_tuser ? 1'b0 : fin_q;
  assign skip    = e_fin || (e_bw >= total_i);

  // Size step: clip the run length to what is left of the image
  assign n_full    = CW'(reps_q * pb_i);
  assign remaining = total_i - bw_q;
  assign n_eff     = (WW'(remaining) < WW'(n_full)) ? CW'(remaining) : n_full;
  assign bw_sum    = bw_q + COUNT_BITS'(n_eff);

  assign req_o.pixel = gather_q;
  assign req_o.pb    = pb_i;
  assign req_o.lane  = lane_q;
  assign req_o.left  = cnt_q;

  // Datapath updates
  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    gidx_d   = gidx_q;
    bw_d     = bw_q;
    fin_d    = fin_q;
    gather_d = gather_q;
    reps_d   = reps_q;
    cnt_d    = cnt_q;
    lane_d   = lane_q;
    done_d   = done_q;
    pix_done = 1'b0;
    if (s_hs) begin
      phase_d = e_phase;
      left_d  = e_left;
      gidx_d  = e_gidx;
      bw_d    = e_bw;
      fin_d   = e_fin;
      if (skip) begin
        fin_d = 1'b1;
      end else begin
        case (e_phase)
          tga_rle_pkg::PH_RUN, tga_rle_pkg::PH_RAW: begin
            gather_d[{e_gidx, 3'b000} +: 8] = s_axis_tdata;
            if ({1'b0, e_gidx} + 3'd1 < pb_i) begin
              gidx_d = e_gidx + 2'd1;
            end else begin
              gidx_d   = 2'd0;
              pix_done = 1'b1;
              if (e_phase == tga_rle_pkg::PH_RUN) begin
                reps_d  = e_left;
                left_d  = 8'd0;
                phase_d = tga_rle_pkg::PH_HEADER;
              end else begin
                reps_d = 8'd1;
                left_d = e_left - 8'd1;
                if (e_left == 8'd1) phase_d = tga_rle_pkg::PH_HEADER;
              end
            end
          end
          default: begin
            gidx_d = 2'd0;
            if ((s_axis_tdata & tga_rle_pkg::RUN_FLAG) != 8'd0) begin
              left_d  = s_axis_tdata - tga_rle_pkg::RUN_BIAS;
              phase_d = tga_rle_pkg::PH_RUN;
            end else begin
              left_d  = s_axis_tdata + 8'd1;
              phase_d = tga_rle_pkg::PH_RAW;
            end
          end
        endcase
      end
    end
    if (state_q == tga_rle_pkg::ST_SIZE) begin
      cnt_d  = n_eff;
      lane_d = 2'd0;
      bw_d   = bw_sum;
      done_d = (bw_sum >= total_i);
      if (bw_sum >= total_i) fin_d = 1'b1;
    end
    if (load) begin
      cnt_d  = cnt_q - CW'(rsp_i.count);
      lane_d = rsp_i.next_lane;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tga_rle_pkg::ST_IDLE: if (s_hs && !skip && pix_done) state_d = tga_rle_pkg::ST_SIZE;
      tga_rle_pkg::ST_SIZE: state_d = tga_rle_pkg::ST_EMIT;
      tga_rle_pkg::ST_EMIT: if (out_free && rsp_i.final_word) state_d = tga_rle_pkg::ST_IDLE;
      default:              state_d = tga_rle_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load          = 1'b0;
    case (state_q)
      tga_rle_pkg::ST_IDLE: s_axis_tready = 1'b1;
      tga_rle_pkg::ST_EMIT: load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    mv_d = mv_q;
    if (load) mv_d = 1'b1;
    else if (m_axis_tready) mv_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tga_rle_pkg::ST_IDLE;
      phase_q <= tga_rle_pkg::PH_HEADER;
      left_q  <= '0;
      gidx_q  <= '0;
      bw_q    <= '0;
      fin_q   <= 1'b0;
      cnt_q   <= '0;
      lane_q  <= '0;
      done_q  <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      left_q  <= left_d;
      gidx_q  <= gidx_d;
      bw_q    <= bw_d;
      fin_q   <= fin_d;
      cnt_q   <= cnt_d;
      lane_q  <= lane_d;
      done_q  <= done_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gather_q <= gather_d;
    reps_q   <= reps_d;
    if (load) begin
      mword_q  <= rsp_i.word;
      mcount_q <= rsp_i.count;
      mlast_q  <= rsp_i.final_word;
      mdone_q  <= rsp_i.final_word && done_q;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign out_word_o    = mword_q;
  assign out_count_o   = mcount_q;
  assign m_axis_tlast  = mlast_q;
  assign m_axis_tuser  = mdone_q;

  a_emit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tga_rle_pkg::ST_EMIT |-> cnt_q != '0)
    else $error("emit with no bytes left");

  a_size_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tga_rle_pkg::ST_SIZE |=> state_q == tga_rle_pkg::ST_EMIT)
    else $error("size step not followed by emit");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_q && mdone_q |-> mlast_q)
    else $error("image done flagged on a non-final word");

  a_final_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && rsp_i.final_word |=> state_q == tga_rle_pkg::ST_IDLE && mv_q && mlast_q)
    else $error("final word did not end the emit");

endmodule

`default_nettype wire

### src/tga_rle_pixel_decoder.sv
// Channel   | Signals                          | Content
// ----------+----------------------------------+-------------------------------------------
// in        | s_axis_tvalid/tready/tdata/tuser | tdata[7:0] data_byte; tuser begins_image
// out       | m_axis_tvalid/tready/tdata/tlast | tdata[63:0] packed_bytes, [67:64] byte_count,
//           | m_axis_tuser                     | [71:68] zero; tlast last; tuser image_done
// config    | cfg_valid_i/ready_o/index_i/data | index 0 pixel_bytes, 1 total_bytes
//
// Steps: a header byte, an incomplete pixel byte or a byte after the image
// total is only accepted. A byte completing a pixel is accepted, then a size
// step clips the run to the image total, then the n decoded bytes leave in
// ceil(n/8) words (up to 64 words on a 128-pixel run), one word per cycle
// through the word packer while the output side holds m_axis_tready high.
// Reset clears all control state at once; no clearing pass. The input stays
// not ready from the completing byte until the last word sits in the output
// register; that register lets the next request in while the word waits.
`default_nettype none

module tga_rle_pixel_decoder #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // input stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [7:0]                           s_axis_tdata,  // data_byte
  input  wire logic                                 s_axis_tuser,  // begins_image
  // output stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [71:0]                               m_axis_tdata,  // packed_bytes, byte_count
  output logic                                      m_axis_tlast,  // last
  output logic                                      m_axis_tuser,  // image_done
  // configuration writes
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [tga_rle_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [tga_rle_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  // Total register keeps only the bits the byte counter can compare against
  localparam int unsigned TW = (COUNT_BITS < 24) ? COUNT_BITS : 24;

  logic [2:0]            pixel_bytes_q;
  logic [TW-1:0]         total_q;
  logic [2:0]            pb_eff;
  logic [COUNT_BITS-1:0] total_eff;
  logic [63:0]           out_word;
  logic [3:0]            out_count;

  tga_rle_pkg::emit_req_t req;
  tga_rle_pkg::pack_rsp_t rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_bytes_q <= tga_rle_pkg::PIXEL_BYTES_RST;
      total_q       <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tga_rle_pkg::REG_PIXEL_BYTES: pixel_bytes_q <= cfg_data_i[2:0];
        tga_rle_pkg::REG_TOTAL_BYTES: total_q       <= cfg_data_i[TW-1:0];
        default: ;
      endcase
    end
  end

  // pixel size 0 acts as 1, above 4 as 4
  always_comb begin
    case (pixel_bytes_q)
      3'd0:                   pb_eff = 3'd1;
      3'd1, 3'd2, 3'd3, 3'd4: pb_eff = pixel_bytes_q;
      default:                pb_eff = 3'd4;
    endcase
  end

  assign total_eff = COUNT_BITS'(total_q);

  tga_rle_ctrl #(
    .COUNT_BITS(COUNT_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pb_i          (pb_eff),
    .total_i       (total_eff),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .out_word_o    (out_word),
    .out_count_o   (out_count),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .req_o         (req),
    .rsp_i         (rsp)
  );

  tga_rle_pack u_pack (
    .req_i (req),
    .rsp_o (rsp)
  );

  assign m_axis_tdata = {4'b0000, out_count, out_word};

endmodule

`default_nettype wire
